@@ rtl/core/sphere_triangle_subdivider_macros.svh @@
// assertion macros for the sphere triangle subdivider
// depends on clk and rst in the including module
`ifndef SPHERE_TRIANGLE_SUBDIVIDER_MACROS_SVH
`define SPHERE_TRIANGLE_SUBDIVIDER_MACROS_SVH

// implication checked on every clock edge outside reset
`define STS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication with the consequent checked in the cycle after the antecedent
`define STS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/sts_pkg.sv @@
// shared constants and types for the sphere triangle subdivider
// no dependencies
package sts_pkg;
  localparam int FRAC_BITS  = 16;
  localparam int COORD_BITS = FRAC_BITS + 2;
  localparam int SQ_BITS    = 2 * COORD_BITS + 2;
  localparam int ROOT_BITS  = SQ_BITS / 2;
  localparam int NUM_PTS    = 6;
  localparam int PT_BITS    = 3;
  localparam int DIV_NUM_BITS = COORD_BITS + FRAC_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [PT_BITS-1:0] pt_idx_t;

  // point slots in the work buffer
  localparam pt_idx_t PT_A   = 3'd0;
  localparam pt_idx_t PT_MAB = 3'd1;
  localparam pt_idx_t PT_B   = 3'd2;
  localparam pt_idx_t PT_MBC = 3'd3;
  localparam pt_idx_t PT_C   = 3'd4;
  localparam pt_idx_t PT_MCA = 3'd5;

  // emit order: slot for each output position
  function automatic pt_idx_t emit_slot(input logic cont, input logic [2:0] k);
    pt_idx_t r;
    r = PT_A;
    if (cont) begin
      case (k)
        3'd0: r = PT_MAB;
        3'd1: r = PT_B;
        3'd2: r = PT_MBC;
        3'd3: r = PT_MCA;
        3'd4: r = PT_MBC;
        3'd5: r = PT_C;
        default: r = PT_A;
      endcase
    end else begin
      case (k)
        3'd0: r = PT_MAB;
        3'd1: r = PT_B;
        3'd2: r = PT_MBC;
        3'd3: r = PT_A;
        3'd4: r = PT_MAB;
        3'd5: r = PT_MCA;
        3'd6: r = PT_MBC;
        default: r = PT_C;
      endcase
    end
    return r;
  endfunction
endpackage

@@ rtl/core/sphere_triangle_subdivider.sv @@
// top level of the sphere triangle subdivider: midpoints, point sequencer
// depends on sts_pkg, sts_norm_pipe and sphere_triangle_subdivider_macros.svh
//
//  channel | signals                                   | dir
//  in      | in_valid/in_ready, ax..cz, strip_continue | in
//  out     | out_valid/out_ready, px,py,pz,point_role, | out
//          | degenerate, last                          |
//
// one triangle is taken per 6 or 8 emitted points (6 with strip_continue), set by the
// single point sequencer feeding the projection pipeline; the next triangle is taken
// as the last point of the current one issues. each point passes 56 register stages
// (magnitudes, sum of squares, 19 root bits, 34 quotient bits, output register).
// the whole pipe freezes while the output register holds a point not taken, so
// in_ready follows out_ready in the same cycle. reset clears valids.
module sphere_triangle_subdivider
  import sts_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t ax,
  input  coord_t ay,
  input  coord_t az,
  input  coord_t bx,
  input  coord_t by,
  input  coord_t bz,
  input  coord_t cx,
  input  coord_t cy,
  input  coord_t cz,
  input  logic   strip_continue,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t px,
  output coord_t py,
  output coord_t pz,
  output logic   point_role,
  output logic   degenerate,
  output logic   last
);
  `include "sphere_triangle_subdivider_macros.svh"

  coord_t pts_x [NUM_PTS];
  coord_t pts_y [NUM_PTS];
  coord_t pts_z [NUM_PTS];
  logic       busy;
  logic       cont;
  logic [2:0] k;
  logic       en;
  logic       issue;
  logic [2:0] k_end;

  // midpoint with floor halving
  function automatic coord_t mid(input coord_t p, input coord_t q);
    logic signed [COORD_BITS:0] s;
    s = {p[COORD_BITS-1], p} + {q[COORD_BITS-1], q};
    return coord_t'(s >>> 1);
  endfunction

  assign k_end = cont ? 3'd5 : 3'd7;
  assign issue = busy && en;
  assign in_ready = en && (!busy || (k == k_end));

  // point sequencer, loads a new triangle as the last point issues
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k <= '0;
    end else if (en) begin
      if (in_valid && in_ready) begin
        busy <= 1'b1;
        k <= '0;
        cont <= strip_continue;
        pts_x[PT_A] <= ax; pts_y[PT_A] <= ay; pts_z[PT_A] <= az;
        pts_x[PT_B] <= bx; pts_y[PT_B] <= by; pts_z[PT_B] <= bz;
        pts_x[PT_C] <= cx; pts_y[PT_C] <= cy; pts_z[PT_C] <= cz;
        pts_x[PT_MAB] <= mid(ax, bx); pts_y[PT_MAB] <= mid(ay, by);
        pts_z[PT_MAB] <= mid(az, bz);
        pts_x[PT_MBC] <= mid(bx, cx); pts_y[PT_MBC] <= mid(by, cy);
        pts_z[PT_MBC] <= mid(bz, cz);
        pts_x[PT_MCA] <= mid(cx, ax); pts_y[PT_MCA] <= mid(cy, ay);
        pts_z[PT_MCA] <= mid(cz, az);
      end else if (busy) begin
        if (k == k_end) begin
          busy <= 1'b0;
        end else begin
          k <= k + 3'd1;
        end
      end
    end
  end

  pt_idx_t sel;
  assign sel = emit_slot(cont, k);

  logic   n_valid, n_role, n_last, n_deg;
  coord_t n_x, n_y, n_z;

  sts_norm_pipe u_norm (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(issue),
    .in_x(pts_x[sel]), .in_y(pts_y[sel]), .in_z(pts_z[sel]),
    .in_role(k >= 3'd3), .in_last(k == k_end),
    .out_valid(n_valid), .out_x(n_x), .out_y(n_y), .out_z(n_z),
    .out_role(n_role), .out_last(n_last), .out_deg(n_deg)
  );

  // output register; pipe advances when it is empty or being taken
  assign en = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= n_valid;
      px <= n_x; py <= n_y; pz <= n_z;
      point_role <= n_role;
      degenerate <= n_deg;
      last <= n_last;
    end
  end

  `STS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(px))
  `STS_ASSERT_IMPL(a_deg_zero, out_valid && degenerate, px == '0 && py == '0 && pz == '0)
  `STS_ASSERT_IMPL(a_ready_seq, in_ready && busy, k == k_end)
  `STS_ASSERT_IMPL(a_last_role, out_valid && last, point_role)
endmodule

@@ rtl/core/sts_norm_pipe.sv @@
// pipelined unit-sphere projection of one point per cycle while en is high
// depends on sts_pkg
module sts_norm_pipe
  import sts_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  coord_t in_x,
  input  coord_t in_y,
  input  coord_t in_z,
  input  logic   in_role,
  input  logic   in_last,
  output logic   out_valid,
  output coord_t out_x,
  output coord_t out_y,
  output coord_t out_z,
  output logic   out_role,
  output logic   out_last,
  output logic   out_deg
);
  // stage layout: 0 magnitudes, 1 sum of squares, 2..RS+1 root bits,
  // then DS divide steps on three lanes
  localparam int RS = ROOT_BITS;
  localparam int DS = DIV_NUM_BITS;
  localparam int NST = 2 + RS + DS;
  localparam int MB = COORD_BITS - 1;

  typedef struct packed {
    logic               v;
    logic               role;
    logic               last;
    logic [2:0]         sgn;
    logic [MB:0]        m0, m1, m2;
    logic [SQ_BITS-1:0] s;      // sum of squares, then remainder
    logic [ROOT_BITS-1:0] root;
    logic [DS-1:0]      n0, n1, n2;  // numerator shift regs / quotients
    logic [ROOT_BITS+1:0] r0, r1, r2; // division remainders
  } st_t;

  st_t st [NST];
  st_t st_next [NST];

  // input stage: magnitudes
  always_comb begin
    st_next[0] = '0;
    st_next[0].v = in_valid;
    st_next[0].role = in_role;
    st_next[0].last = in_last;
    st_next[0].sgn = {in_z[MB], in_y[MB], in_x[MB]};
    st_next[0].m0 = in_x[MB] ? (MB+1)'(-in_x) : (MB+1)'(in_x);
    st_next[0].m1 = in_y[MB] ? (MB+1)'(-in_y) : (MB+1)'(in_y);
    st_next[0].m2 = in_z[MB] ? (MB+1)'(-in_z) : (MB+1)'(in_z);
  end

  // sum of squares
  always_comb begin
    st_next[1] = st[0];
    st_next[1].s = SQ_BITS'(st[0].m0) * SQ_BITS'(st[0].m0)
                 + SQ_BITS'(st[0].m1) * SQ_BITS'(st[0].m1)
                 + SQ_BITS'(st[0].m2) * SQ_BITS'(st[0].m2);
    st_next[1].root = '0;
  end

  // digit-by-digit square root, one result bit per stage
  for (genvar i = 0; i < RS; i++) begin : g_sqrt
    localparam int B = RS - 1 - i;
    always_comb begin
      logic [SQ_BITS+1:0] trial;
      logic [SQ_BITS+1:0] rem;
      st_next[2+i] = st[1+i];
      rem = (SQ_BITS+2)'(st[1+i].s);
      trial = ((SQ_BITS+2)'(st[1+i].root) << (B + 1)) + ((SQ_BITS+2)'(1) << (2*B));
      if (rem >= trial) begin
        st_next[2+i].s = SQ_BITS'(rem - trial);
        st_next[2+i].root = st[1+i].root | (ROOT_BITS'(1) << B);
      end
    end
  end

  // restoring division, one quotient bit per stage on three lanes
  for (genvar j = 0; j < DS; j++) begin : g_div
    localparam int P = 2 + RS + j;
    always_comb begin
      logic [ROOT_BITS+1:0] t0, t1, t2, l;
      st_next[P] = st[P-1];
      if (j == 0) begin
        // load numerators: magnitude shifted, plus half the root for rounding
        st_next[P].n0 = (DS'(st[P-1].m0) << FRAC_BITS) + DS'(st[P-1].root >> 1);
        st_next[P].n1 = (DS'(st[P-1].m1) << FRAC_BITS) + DS'(st[P-1].root >> 1);
        st_next[P].n2 = (DS'(st[P-1].m2) << FRAC_BITS) + DS'(st[P-1].root >> 1);
      end
      l = (ROOT_BITS+2)'(st[P-1].root);
      t0 = {st_next[P].r0[ROOT_BITS:0], st_next[P].n0[DS-1]};
      t1 = {st_next[P].r1[ROOT_BITS:0], st_next[P].n1[DS-1]};
      t2 = {st_next[P].r2[ROOT_BITS:0], st_next[P].n2[DS-1]};
      st_next[P].n0 = {st_next[P].n0[DS-2:0], t0 >= l};
      st_next[P].n1 = {st_next[P].n1[DS-2:0], t1 >= l};
      st_next[P].n2 = {st_next[P].n2[DS-2:0], t2 >= l};
      st_next[P].r0 = (t0 >= l) ? t0 - l : t0;
      st_next[P].r1 = (t1 >= l) ? t1 - l : t1;
      st_next[P].r2 = (t2 >= l) ? t2 - l : t2;
    end
  end

  // pipeline registers, frozen on stall
  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (rst) begin
        st[k].v <= 1'b0;
      end else if (en) begin
        st[k] <= st_next[k];
      end
    end
  end

  st_t fin;
  assign fin = st[NST-1];

  // output formatting
  always_comb begin
    logic [DS-1:0] q0, q1, q2;
    q0 = fin.n0; q1 = fin.n1; q2 = fin.n2;
    out_valid = fin.v;
    out_role  = fin.role;
    out_last  = fin.last;
    out_deg   = (fin.root == '0);
    out_x = out_deg ? '0 : (fin.sgn[0] ? -coord_t'(q0) : coord_t'(q0));
    out_y = out_deg ? '0 : (fin.sgn[1] ? -coord_t'(q1) : coord_t'(q1));
    out_z = out_deg ? '0 : (fin.sgn[2] ? -coord_t'(q2) : coord_t'(q2));
  end
endmodule
